// File: rtl/core/dpt_pkg.sv
// Package for the detection presence tracker: register codes, reset values
// and fixed field widths. No dependencies.
`default_nettype none
package dpt_pkg;

  typedef enum logic [2:0] {
    REG_IOU_CONFIRM = 3'd0,
    REG_IOU_SNAP    = 3'd1,
    REG_BLEND_ALPHA = 3'd2,
    REG_ENTER       = 3'd3,
    REG_EXIT        = 3'd4,
    REG_META_BASE   = 3'd5,
    REG_PLATFORM    = 3'd6
  } reg_idx_e;

  localparam logic [15:0] RST_IOU_CONFIRM = 16'd36045;
  localparam logic [15:0] RST_IOU_SNAP    = 16'd32768;
  localparam logic [15:0] RST_BLEND_ALPHA = 16'd32768;
  localparam logic [7:0]  RST_ENTER       = 8'd5;
  localparam logic [7:0]  RST_EXIT        = 8'd3;
  localparam logic [7:0]  RST_META_BASE   = 8'd128;
  localparam logic [7:0]  RST_PLATFORM    = 8'd128;

  localparam int unsigned PADDR_W = 5;
  localparam logic [7:0]  RUN_MAX = 8'd255;

endpackage
`default_nettype wire

// File: rtl/core/detection_presence_tracker.sv
// Detection presence tracker top level: box stores, frame-end sequencer and
// one shared multiplier for overlap tests and blending. Depends on dpt_pkg.
`default_nettype none
//
// Channel      Dir   Handshake                    Payload
// input box    in    in_valid_i / in_ready_o      box_valid_i .. frame_last_i
// result box   out   res_valid_o / res_ready_i    out_valid_o .. out_last_o
// config       in    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// An item that does not close a frame is accepted while in_ready_o stays high.
// The item with frame_last_i set starts the frame-end sequence, during which
// in_ready_o is low: a scan of every stored box, then the confirmation or
// smoothing pass. That pass reads each frame box and each stored box it looks
// at, runs an overlap test on same-class box pairs, and when smoothing blends
// and writes back each matched box. Then comes a copy of each box and the
// publish of each beat. The shared multiplier and the single read port of each
// box store set the pace of these steps. A stalled result beat holds the
// sequencer in its publish step; reset clears all control state, and the box
// stores need no clearing since every read is bounded by a fill count.
module detection_presence_tracker import dpt_pkg::*; #(
  parameter int MAX_BOXES  = 16,
  parameter int COORD_BITS = 16
) (
  input  wire  logic                 clk_i,
  input  wire  logic                 rst_ni,
  input  wire  logic                 in_valid_i,
  output logic                       in_ready_o,
  input  wire  logic                 box_valid_i,
  input  wire  logic [7:0]           class_code_i,
  input  wire  logic [15:0]          left_x_i,
  input  wire  logic [15:0]          top_y_i,
  input  wire  logic [15:0]          right_x_i,
  input  wire  logic [15:0]          bottom_y_i,
  input  wire  logic [15:0]          confidence_i,
  input  wire  logic [31:0]          frame_number_i,
  input  wire  logic                 frame_last_i,
  output logic                       res_valid_o,
  input  wire  logic                 res_ready_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_class_o,
  output logic [15:0]                out_left_o,
  output logic [15:0]                out_top_o,
  output logic [15:0]                out_right_o,
  output logic [15:0]                out_bottom_o,
  output logic [15:0]                out_score_o,
  output logic [31:0]                out_frame_o,
  output logic                       target_present_o,
  output logic                       platform_seen_o,
  output logic                       out_last_o,
  input  wire  logic                 psel,
  input  wire  logic                 penable,
  input  wire  logic                 pwrite,
  input  wire  logic [PADDR_W-1:0]   paddr,
  input  wire  logic [31:0]          pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CB     = COORD_BITS;
  localparam int IW     = $clog2(MAX_BOXES);
  localparam int CW     = $clog2(MAX_BOXES + 1);
  localparam int AREA_W = 2 * CB;
  localparam int MA_W   = AREA_W + 1;
  localparam int MB_W   = 17;
  localparam int P_W    = MA_W + MB_W;
  localparam int ACC_W  = CB + 17;

  typedef struct packed {
    logic [7:0]    cls;
    logic [CB-1:0] l;
    logic [CB-1:0] t;
    logic [CB-1:0] r;
    logic [CB-1:0] b;
    logic [15:0]   score;
  } box_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN_A, ST_SCAN_B, ST_DECIDE,
    ST_MT_IA, ST_MT_IB, ST_MT_JA, ST_MT_JB, ST_MT_RET, ST_ENTER,
    ST_SM_IA, ST_SM_IB, ST_SM_JA, ST_SM_JB, ST_SM_RET, ST_BLEND, ST_SM_WB,
    ST_OV_INT, ST_OV_AA, ST_OV_AB, ST_OV_UN, ST_OV_CMP,
    ST_CP_A, ST_CP_B, ST_PUB_A, ST_PUB_B
  } state_e;

  // Configuration registers.
  logic [15:0] iou_confirm_q, iou_snap_q, blend_alpha_q;
  logic [7:0]  enter_frames_q, exit_frames_q, meta_base_q, platform_class_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_confirm_q    <= RST_IOU_CONFIRM;
      iou_snap_q       <= RST_IOU_SNAP;
      blend_alpha_q    <= RST_BLEND_ALPHA;
      enter_frames_q   <= RST_ENTER;
      exit_frames_q    <= RST_EXIT;
      meta_base_q      <= RST_META_BASE;
      platform_class_q <= RST_PLATFORM;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[PADDR_W-1:2]))
        REG_IOU_CONFIRM: iou_confirm_q    <= pwdata[15:0];
        REG_IOU_SNAP:    iou_snap_q       <= pwdata[15:0];
        REG_BLEND_ALPHA: blend_alpha_q    <= pwdata[15:0];
        REG_ENTER:       enter_frames_q   <= pwdata[7:0];
        REG_EXIT:        exit_frames_q    <= pwdata[7:0];
        REG_META_BASE:   meta_base_q      <= pwdata[7:0];
        REG_PLATFORM:    platform_class_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[PADDR_W-1:2]))
      REG_IOU_CONFIRM: prdata = {16'h0, iou_confirm_q};
      REG_IOU_SNAP:    prdata = {16'h0, iou_snap_q};
      REG_BLEND_ALPHA: prdata = {16'h0, blend_alpha_q};
      REG_ENTER:       prdata = {24'h0, enter_frames_q};
      REG_EXIT:        prdata = {24'h0, exit_frames_q};
      REG_META_BASE:   prdata = {24'h0, meta_base_q};
      REG_PLATFORM:    prdata = {24'h0, platform_class_q};
      default:         prdata = 32'h0;
    endcase
  end

  // Sequencer registers.
  state_e         state_q, ret_q;
  logic [CW-1:0]  frame_fill_q, held_fill_q, cand_fill_q;
  logic [CW-1:0]  i_q, j_q, pub_n_q;
  logic [IW-1:0]  plat_idx_q;
  logic           present_q, held_ok_q, cand_ok_q, plat_now_q, target_hit_q;
  logic           match_q, hit_q, cp_held_q, cp_cand_q, pub_held_q;
  logic [7:0]     enter_run_q, exit_run_q;
  logic [31:0]    frame_num_q;
  logic [15:0]    thr_q;
  box_t           box_a_q, box_b_q;
  logic [AREA_W-1:0] inter_q, area_a_q;
  logic [3:0]     k_q;
  logic [ACC_W-1:0] acc_q;
  logic           res_valid_q;

  // Box stores, each with one write port and one registered read port.
  box_t frame_mem [MAX_BOXES];
  box_t held_mem  [MAX_BOXES];
  box_t cand_mem  [MAX_BOXES];
  box_t frame_rd_q, held_rd_q, cand_rd_q;
  logic [IW-1:0] frame_ra, held_ra, cand_ra, frame_wa;
  logic          frame_we, held_we, cand_we;
  box_t          frame_wd, in_box;

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    in_box.cls   = class_code_i;
    in_box.l     = left_x_i[CB-1:0];
    in_box.t     = top_y_i[CB-1:0];
    in_box.r     = right_x_i[CB-1:0];
    in_box.b     = bottom_y_i[CB-1:0];
    in_box.score = confidence_i;
  end

  logic pub_state, pub_tail;
  assign pub_state = (state_q == ST_PUB_A) || (state_q == ST_PUB_B);
  assign pub_tail  = pub_held_q && (i_q == held_fill_q);

  always_comb begin
    frame_ra = pub_state && pub_tail ? plat_idx_q : i_q[IW-1:0];
    held_ra  = pub_state ? i_q[IW-1:0] : j_q[IW-1:0];
    cand_ra  = j_q[IW-1:0];
    frame_we = 1'b0;
    frame_wa = i_q[IW-1:0];
    frame_wd = box_b_q;
    if (state_q == ST_IDLE) begin
      frame_we = in_acc && box_valid_i && (frame_fill_q < CW'(MAX_BOXES));
      frame_wa = frame_fill_q[IW-1:0];
      frame_wd = in_box;
    end else if (state_q == ST_SM_WB) begin
      frame_we = 1'b1;
    end
    held_we = (state_q == ST_CP_B) && cp_held_q;
    cand_we = (state_q == ST_CP_B) && cp_cand_q;
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) frame_mem[frame_wa] <= frame_wd;
    if (held_we) held_mem[i_q[IW-1:0]] <= frame_rd_q;
    if (cand_we) cand_mem[i_q[IW-1:0]] <= frame_rd_q;
    frame_rd_q <= frame_mem[frame_ra];
    held_rd_q  <= held_mem[held_ra];
    cand_rd_q  <= cand_mem[cand_ra];
  end

  // Overlap geometry of box_a_q and box_b_q.
  logic [CB-1:0] x1, y1, x2, y2, iw, ih, wa, ha, wb, hb;
  logic [MA_W-1:0] uni;
  always_comb begin
    x1 = box_a_q.l > box_b_q.l ? box_a_q.l : box_b_q.l;
    y1 = box_a_q.t > box_b_q.t ? box_a_q.t : box_b_q.t;
    x2 = box_a_q.r < box_b_q.r ? box_a_q.r : box_b_q.r;
    y2 = box_a_q.b < box_b_q.b ? box_a_q.b : box_b_q.b;
    iw = x2 > x1 ? x2 - x1 : '0;
    ih = y2 > y1 ? y2 - y1 : '0;
    wa = box_a_q.r > box_a_q.l ? box_a_q.r - box_a_q.l : '0;
    ha = box_a_q.b > box_a_q.t ? box_a_q.b - box_a_q.t : '0;
    wb = box_b_q.r > box_b_q.l ? box_b_q.r - box_b_q.l : '0;
    hb = box_b_q.b > box_b_q.t ? box_b_q.b - box_b_q.t : '0;
  end

  // Shared multiplier.
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [P_W-1:0]  mul_q;
  logic [1:0]      bl_c;
  logic [CB-1:0]   bl_prev, bl_cur;

  assign bl_c = k_q[2:1];
  always_comb begin
    case (bl_c)
      2'd0:    begin bl_prev = box_a_q.l; bl_cur = box_b_q.l; end
      2'd1:    begin bl_prev = box_a_q.t; bl_cur = box_b_q.t; end
      2'd2:    begin bl_prev = box_a_q.r; bl_cur = box_b_q.r; end
      default: begin bl_prev = box_a_q.b; bl_cur = box_b_q.b; end
    endcase
  end

  always_comb begin
    uni   = MA_W'(area_a_q) + MA_W'(mul_q[AREA_W-1:0]) - MA_W'(inter_q);
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_OV_INT: begin mul_a = MA_W'(iw); mul_b = MB_W'(ih); end
      ST_OV_AA:  begin mul_a = MA_W'(wa); mul_b = MB_W'(ha); end
      ST_OV_AB:  begin mul_a = MA_W'(wb); mul_b = MB_W'(hb); end
      ST_OV_UN:  begin mul_a = uni;       mul_b = MB_W'(thr_q); end
      ST_BLEND: begin
        if (k_q[0]) begin
          mul_a = MA_W'(bl_cur);
          mul_b = MB_W'(blend_alpha_q);
        end else begin
          mul_a = MA_W'(bl_prev);
          mul_b = 17'h10000 - MB_W'(blend_alpha_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // Helper values for the sequencer.
  logic [CW-1:0]    i_inc, j_inc;
  logic [7:0]       exit_inc, enter_inc, enter_new;
  logic [ACC_W-1:0] acc_sum;
  logic [CB-1:0]    bl_res;
  logic [P_W-1:0]   inter_sh;
  logic             frame_tgt, other_tgt_c, other_tgt_h, coast_c;
  box_t             pub_box;

  always_comb begin
    i_inc       = i_q + CW'(1);
    j_inc       = j_q + CW'(1);
    exit_inc    = (exit_run_q == RUN_MAX) ? RUN_MAX : exit_run_q + 8'd1;
    enter_inc   = (enter_run_q == RUN_MAX) ? RUN_MAX : enter_run_q + 8'd1;
    enter_new   = match_q ? enter_inc : 8'd1;
    acc_sum     = acc_q + mul_q[ACC_W-1:0];
    bl_res      = acc_sum[CB+15:16];
    inter_sh    = {{(P_W-AREA_W-16){1'b0}}, inter_q, 16'h0};
    frame_tgt   = frame_rd_q.cls < meta_base_q;
    other_tgt_c = cand_rd_q.cls < meta_base_q;
    other_tgt_h = held_rd_q.cls < meta_base_q;
    pub_box     = (pub_held_q && !pub_tail) ? held_rd_q : frame_rd_q;
    // A frame without targets while present republishes the held boxes until the exit run reaches exit_frames_q.
    coast_c     = present_q && !target_hit_q && held_ok_q && (exit_inc < exit_frames_q);
  end

  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      ret_q            <= ST_IDLE;
      frame_fill_q     <= '0;
      held_fill_q      <= '0;
      cand_fill_q      <= '0;
      i_q              <= '0;
      j_q              <= '0;
      pub_n_q          <= '0;
      plat_idx_q       <= '0;
      present_q        <= 1'b0;
      held_ok_q        <= 1'b0;
      cand_ok_q        <= 1'b0;
      plat_now_q       <= 1'b0;
      target_hit_q     <= 1'b0;
      match_q          <= 1'b0;
      hit_q            <= 1'b0;
      cp_held_q        <= 1'b0;
      cp_cand_q        <= 1'b0;
      pub_held_q       <= 1'b0;
      enter_run_q      <= '0;
      exit_run_q       <= '0;
      frame_num_q      <= '0;
      thr_q            <= '0;
      box_a_q          <= '0;
      box_b_q          <= '0;
      inter_q          <= '0;
      area_a_q         <= '0;
      k_q              <= '0;
      acc_q            <= '0;
      res_valid_q      <= 1'b0;
      out_valid_o      <= 1'b0;
      out_class_o      <= '0;
      out_left_o       <= '0;
      out_top_o        <= '0;
      out_right_o      <= '0;
      out_bottom_o     <= '0;
      out_score_o      <= '0;
      out_frame_o      <= '0;
      target_present_o <= 1'b0;
      platform_seen_o  <= 1'b0;
      out_last_o       <= 1'b0;
    end else begin
      // The publish step sets valid itself whenever it hands over a beat.
      if (res_valid_q && res_ready_i && (state_q != ST_PUB_B)) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (box_valid_i && (frame_fill_q < CW'(MAX_BOXES))) begin
              frame_fill_q <= frame_fill_q + CW'(1);
            end
            if (frame_last_i) begin
              frame_num_q  <= frame_number_i;
              i_q          <= '0;
              target_hit_q <= 1'b0;
              plat_now_q   <= 1'b0;
              state_q      <= ST_SCAN_A;
            end
          end
        end
        ST_SCAN_A: begin
          state_q <= (frame_fill_q == '0) ? ST_DECIDE : ST_SCAN_B;
        end
        ST_SCAN_B: begin
          if (frame_tgt) target_hit_q <= 1'b1;
          if (frame_rd_q.cls == platform_class_q && !plat_now_q) begin
            plat_now_q <= 1'b1;
            plat_idx_q <= i_q[IW-1:0];
          end
          i_q     <= i_inc;
          state_q <= (i_inc == frame_fill_q) ? ST_DECIDE : ST_SCAN_A;
        end
        ST_DECIDE: begin
          i_q        <= '0;
          j_q        <= '0;
          match_q    <= 1'b0;
          pub_held_q <= coast_c;
          pub_n_q    <= coast_c ?
                        held_fill_q + CW'(plat_now_q && (held_fill_q < CW'(MAX_BOXES))) :
                        frame_fill_q;
          if (target_hit_q) begin
            exit_run_q <= '0;
            if (present_q) begin
              state_q <= ST_SM_IA;
            end else begin
              state_q <= cand_ok_q ? ST_MT_IA : ST_ENTER;
            end
          end else begin
            enter_run_q <= '0;
            cand_ok_q   <= 1'b0;
            state_q     <= ST_PUB_A;
            if (present_q) begin
              if (coast_c) begin
                exit_run_q <= exit_inc;
              end else begin
                present_q  <= 1'b0;
                held_ok_q  <= 1'b0;
                exit_run_q <= '0;
              end
            end
          end
        end
        // Confirmation pass against the previous candidate frame.
        ST_MT_IA: state_q <= ST_MT_IB;
        ST_MT_IB: begin
          box_a_q <= frame_rd_q;
          j_q     <= '0;
          if (frame_tgt && cand_fill_q != '0) begin
            state_q <= ST_MT_JA;
          end else begin
            i_q     <= i_inc;
            state_q <= (i_inc == frame_fill_q) ? ST_ENTER : ST_MT_IA;
          end
        end
        ST_MT_JA: state_q <= ST_MT_JB;
        ST_MT_JB: begin
          if (other_tgt_c && cand_rd_q.cls == box_a_q.cls) begin
            box_b_q <= cand_rd_q;
            thr_q   <= iou_confirm_q;
            ret_q   <= ST_MT_RET;
            state_q <= ST_OV_INT;
          end else if (j_inc != cand_fill_q) begin
            j_q     <= j_inc;
            state_q <= ST_MT_JA;
          end else begin
            i_q     <= i_inc;
            state_q <= (i_inc == frame_fill_q) ? ST_ENTER : ST_MT_IA;
          end
        end
        ST_MT_RET: begin
          if (hit_q) begin
            match_q <= 1'b1;
            state_q <= ST_ENTER;
          end else if (j_inc != cand_fill_q) begin
            j_q     <= j_inc;
            state_q <= ST_MT_JA;
          end else begin
            i_q     <= i_inc;
            state_q <= (i_inc == frame_fill_q) ? ST_ENTER : ST_MT_IA;
          end
        end
        ST_ENTER: begin
          cand_fill_q <= frame_fill_q;
          cp_cand_q   <= 1'b1;
          i_q         <= '0;
          state_q     <= ST_CP_A;
          if (enter_new >= enter_frames_q) begin
            held_fill_q <= frame_fill_q;
            held_ok_q   <= 1'b1;
            present_q   <= 1'b1;
            enter_run_q <= '0;
            cand_ok_q   <= 1'b0;
            cp_held_q   <= 1'b1;
          end else begin
            enter_run_q <= enter_new;
            cand_ok_q   <= 1'b1;
            cp_held_q   <= 1'b0;
          end
        end
        // Smoothing pass against the first same-class held box.
        ST_SM_IA: state_q <= ST_SM_IB;
        ST_SM_IB: begin
          box_b_q <= frame_rd_q;
          j_q     <= '0;
          if (frame_tgt && held_fill_q != '0) begin
            state_q <= ST_SM_JA;
          end else if (i_inc == frame_fill_q) begin
            i_q         <= '0;
            cp_held_q   <= 1'b1;
            cp_cand_q   <= 1'b0;
            held_fill_q <= frame_fill_q;
            state_q     <= ST_CP_A;
          end else begin
            i_q     <= i_inc;
            state_q <= ST_SM_IA;
          end
        end
        ST_SM_JA: state_q <= ST_SM_JB;
        ST_SM_JB: begin
          if (other_tgt_h && held_rd_q.cls == box_b_q.cls) begin
            box_a_q <= held_rd_q;
            thr_q   <= iou_snap_q;
            ret_q   <= ST_SM_RET;
            state_q <= ST_OV_INT;
          end else if (j_inc != held_fill_q) begin
            j_q     <= j_inc;
            state_q <= ST_SM_JA;
          end else if (i_inc == frame_fill_q) begin
            i_q         <= '0;
            cp_held_q   <= 1'b1;
            cp_cand_q   <= 1'b0;
            held_fill_q <= frame_fill_q;
            state_q     <= ST_CP_A;
          end else begin
            i_q     <= i_inc;
            state_q <= ST_SM_IA;
          end
        end
        ST_SM_RET: begin
          if (hit_q) begin
            if (box_a_q.score > box_b_q.score) box_b_q.score <= box_a_q.score;
            k_q     <= '0;
            acc_q   <= ACC_W'(32768);
            state_q <= ST_BLEND;
          end else if (i_inc == frame_fill_q) begin
            i_q         <= '0;
            cp_held_q   <= 1'b1;
            cp_cand_q   <= 1'b0;
            held_fill_q <= frame_fill_q;
            state_q     <= ST_CP_A;
          end else begin
            i_q     <= i_inc;
            state_q <= ST_SM_IA;
          end
        end
        // Blend step k issues product k and adds product k-1.
        ST_BLEND: begin
          k_q <= k_q + 4'd1;
          if (k_q != 4'd0) begin
            if (!k_q[0]) begin
              acc_q <= ACC_W'(32768);
              case (k_q[2:1] - 2'd1)
                2'd0:    box_b_q.l <= bl_res;
                2'd1:    box_b_q.t <= bl_res;
                2'd2:    box_b_q.r <= bl_res;
                default: box_b_q.b <= bl_res;
              endcase
            end else begin
              acc_q <= acc_sum;
            end
          end
          if (k_q == 4'd8) begin
            state_q <= ST_SM_WB;
          end
        end
        ST_SM_WB: begin
          if (i_inc == frame_fill_q) begin
            i_q         <= '0;
            cp_held_q   <= 1'b1;
            cp_cand_q   <= 1'b0;
            held_fill_q <= frame_fill_q;
            state_q     <= ST_CP_A;
          end else begin
            i_q     <= i_inc;
            state_q <= ST_SM_IA;
          end
        end
        // Exact overlap test: inter * 65536 >= thr * union.
        ST_OV_INT: state_q <= ST_OV_AA;
        ST_OV_AA: begin
          inter_q <= mul_q[AREA_W-1:0];
          state_q <= ST_OV_AB;
        end
        ST_OV_AB: begin
          area_a_q <= mul_q[AREA_W-1:0];
          state_q  <= ST_OV_UN;
        end
        ST_OV_UN: state_q <= ST_OV_CMP;
        ST_OV_CMP: begin
          hit_q   <= (inter_q == '0) ? (thr_q == '0) : (inter_sh >= mul_q);
          state_q <= ret_q;
        end
        ST_CP_A: state_q <= ST_CP_B;
        ST_CP_B: begin
          if (i_inc == frame_fill_q) begin
            i_q        <= '0;
            pub_held_q <= 1'b0;
            pub_n_q    <= frame_fill_q;
            state_q    <= ST_PUB_A;
          end else begin
            i_q     <= i_inc;
            state_q <= ST_CP_A;
          end
        end
        ST_PUB_A: state_q <= ST_PUB_B;
        ST_PUB_B: begin
          if (!res_valid_q || res_ready_i) begin
            res_valid_q      <= 1'b1;
            out_frame_o      <= frame_num_q;
            target_present_o <= present_q;
            platform_seen_o  <= plat_now_q;
            if (pub_n_q == '0) begin
              out_valid_o  <= 1'b0;
              out_class_o  <= '0;
              out_left_o   <= '0;
              out_top_o    <= '0;
              out_right_o  <= '0;
              out_bottom_o <= '0;
              out_score_o  <= '0;
              out_last_o   <= 1'b1;
            end else begin
              out_valid_o  <= 1'b1;
              out_class_o  <= pub_box.cls;
              out_left_o   <= 16'(pub_box.l);
              out_top_o    <= 16'(pub_box.t);
              out_right_o  <= 16'(pub_box.r);
              out_bottom_o <= 16'(pub_box.b);
              out_score_o  <= pub_box.score;
              out_last_o   <= (i_inc == pub_n_q);
            end
            if (pub_n_q == '0 || i_inc == pub_n_q) begin
              frame_fill_q <= '0;
              state_q      <= ST_IDLE;
            end else begin
              i_q     <= i_inc;
              state_q <= ST_PUB_A;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: test/detection_presence_tracker_tb.sv
// Self-checking testbench for detection_presence_tracker: drives frames of boxes,
// writes the registers over APB and checks every result beat against a predictor.
// Depends on dpt_pkg and the detection_presence_tracker RTL.
module detection_presence_tracker_tb;
  import dpt_pkg::*;

  localparam int NBOX = 16;

  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] l, t, r, b, score;
  } box_t;

  typedef struct packed {
    logic        box_valid;
    box_t        bx;
    logic [31:0] frame;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        vld;
    box_t        bx;
    logic [31:0] frame;
    logic        present;
    logic        plat;
    logic        last;
  } beat_t;

  // The scoreboard carries its own copy of the tracker state. Each accepted input
  // beat advances that state; a frame-closing beat queues the result beats the
  // tracker should publish for that frame.
  class presence_scoreboard;
    logic [15:0] thr_confirm, thr_snap, alpha;
    logic [7:0]  enter_n, exit_n, meta_base, plat_cls;
    box_t        cur_st[NBOX], held_st[NBOX], cand_st[NBOX];
    int unsigned cur_n, held_n, cand_n, enter_cnt, exit_cnt;
    bit          present, held_valid, cand_valid;
    beat_t       frame_q[$];
    int unsigned errors;

    function new();
      thr_confirm = RST_IOU_CONFIRM; thr_snap = RST_IOU_SNAP; alpha = RST_BLEND_ALPHA;
      enter_n = RST_ENTER; exit_n = RST_EXIT;
      meta_base = RST_META_BASE; plat_cls = RST_PLATFORM;
      cur_n = 0; held_n = 0; cand_n = 0; enter_cnt = 0; exit_cnt = 0;
      present = 0; held_valid = 0; cand_valid = 0; errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_IOU_CONFIRM: thr_confirm = v[15:0];
        REG_IOU_SNAP:    thr_snap = v[15:0];
        REG_BLEND_ALPHA: alpha = v[15:0];
        REG_ENTER:       enter_n = v[7:0];
        REG_EXIT:        exit_n = v[7:0];
        REG_META_BASE:   meta_base = v[7:0];
        default:         plat_cls = v[7:0];
      endcase
    endfunction

    function longint unsigned area(box_t a);
      longint unsigned w, h;
      w = (a.r > a.l) ? longint'(a.r - a.l) : 0;
      h = (a.b > a.t) ? longint'(a.b - a.t) : 0;
      return w * h;
    endfunction

    // Exact IoU >= thr/65536 test, with cross multiplication instead of division.
    function bit overlap_ok(box_t a, box_t b, logic [15:0] thr);
      logic [15:0] x1, y1, x2, y2;
      longint unsigned iw, ih, inter, uni;
      x1 = (a.l > b.l) ? a.l : b.l;
      y1 = (a.t > b.t) ? a.t : b.t;
      x2 = (a.r < b.r) ? a.r : b.r;
      y2 = (a.b < b.b) ? a.b : b.b;
      iw = (x2 > x1) ? longint'(x2 - x1) : 0;
      ih = (y2 > y1) ? longint'(y2 - y1) : 0;
      inter = iw * ih;
      if (inter == 0) return thr == 0;
      uni = area(a) + area(b) - inter;
      return (inter << 16) >= longint'(thr) * uni;
    endfunction

    function logic [15:0] blend(logic [15:0] prev, logic [15:0] nw);
      longint unsigned v;
      v = longint'(prev) * (65536 - longint'(alpha)) + longint'(nw) * longint'(alpha) + 32768;
      return v[31:16];
    endfunction

    function bit is_target(box_t x);
      return x.cls < meta_base;
    endfunction

    function bit frames_match();
      for (int i = 0; i < cur_n; i++) begin
        if (!is_target(cur_st[i])) continue;
        for (int j = 0; j < cand_n; j++) begin
          if (!is_target(cand_st[j]) || cand_st[j].cls != cur_st[i].cls) continue;
          if (overlap_ok(cur_st[i], cand_st[j], thr_confirm)) return 1;
        end
      end
      return 0;
    endfunction

    // Each target box snaps to the first held box of its class, if close enough.
    function void smooth_boxes();
      for (int i = 0; i < cur_n; i++) begin
        if (!is_target(cur_st[i])) continue;
        for (int j = 0; j < held_n; j++) begin
          if (!is_target(held_st[j]) || held_st[j].cls != cur_st[i].cls) continue;
          if (overlap_ok(held_st[j], cur_st[i], thr_snap)) begin
            cur_st[i].l = blend(held_st[j].l, cur_st[i].l);
            cur_st[i].t = blend(held_st[j].t, cur_st[i].t);
            cur_st[i].r = blend(held_st[j].r, cur_st[i].r);
            cur_st[i].b = blend(held_st[j].b, cur_st[i].b);
            if (held_st[j].score > cur_st[i].score) cur_st[i].score = held_st[j].score;
          end
          break;
        end
      end
    endfunction

    function void note_item(item_t it);
      box_t        pub[NBOX];
      int unsigned npub;
      bit          hit, plat_now;
      beat_t       e;
      if (it.box_valid && cur_n < NBOX) begin
        cur_st[cur_n] = it.bx;
        cur_n++;
      end
      if (!it.last) return;
      hit = 0;
      plat_now = 0;
      for (int i = 0; i < cur_n; i++) begin
        if (is_target(cur_st[i])) hit = 1;
        if (cur_st[i].cls == plat_cls) plat_now = 1;
      end
      npub = cur_n;
      if (hit) begin
        exit_cnt = 0;
        if (present) begin
          smooth_boxes();
          held_st = cur_st;
          held_n = cur_n;
        end else begin
          if (cand_valid && frames_match()) begin
            if (enter_cnt < 255) enter_cnt++;
          end else begin
            enter_cnt = 1;
          end
          cand_st = cur_st;
          cand_n = cur_n;
          cand_valid = 1;
          if (enter_cnt >= enter_n) begin
            held_st = cur_st;
            held_n = cur_n;
            held_valid = 1;
            present = 1;
            enter_cnt = 0;
            cand_valid = 0;
          end
        end
        pub = cur_st;
      end else begin
        enter_cnt = 0;
        cand_valid = 0;
        pub = cur_st;
        if (present) begin
          if (exit_cnt < 255) exit_cnt++;
          if (exit_cnt < exit_n && held_valid) begin
            // Coasting: republish the held boxes plus the first platform box.
            pub = held_st;
            npub = held_n;
            if (plat_now && npub < NBOX) begin
              for (int i = 0; i < cur_n; i++) begin
                if (cur_st[i].cls == plat_cls) begin
                  pub[npub] = cur_st[i];
                  npub++;
                  break;
                end
              end
            end
          end else begin
            present = 0;
            held_valid = 0;
            exit_cnt = 0;
          end
        end
      end
      e.frame = it.frame;
      e.present = present;
      e.plat = plat_now;
      if (npub == 0) begin
        e.vld = 0;
        e.bx = '0;
        e.last = 1;
        frame_q.push_back(e);
      end
      for (int i = 0; i < npub; i++) begin
        e.vld = 1;
        e.bx = pub[i];
        e.last = (i + 1 == npub);
        frame_q.push_back(e);
      end
      cur_n = 0;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(beat_t r);
      beat_t e;
      if (frame_q.size() == 0) begin
        report("unexpected result beat, frame", r.frame, 0);
        return;
      end
      e = frame_q.pop_front();
      if (r.vld !== e.vld)           report("out_valid", r.vld, e.vld);
      if (r.bx.cls !== e.bx.cls)     report("out_class", r.bx.cls, e.bx.cls);
      if (r.bx.l !== e.bx.l)         report("out_left", r.bx.l, e.bx.l);
      if (r.bx.t !== e.bx.t)         report("out_top", r.bx.t, e.bx.t);
      if (r.bx.r !== e.bx.r)         report("out_right", r.bx.r, e.bx.r);
      if (r.bx.b !== e.bx.b)         report("out_bottom", r.bx.b, e.bx.b);
      if (r.bx.score !== e.bx.score) report("out_score", r.bx.score, e.bx.score);
      if (r.frame !== e.frame)       report("out_frame", r.frame, e.frame);
      if (r.present !== e.present)   report("target_present", r.present, e.present);
      if (r.plat !== e.plat)         report("platform_seen", r.plat, e.plat);
      if (r.last !== e.last)         report("out_last", r.last, e.last);
    endtask

    function int outstanding();
      return frame_q.size();
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_ready_o;
  item_t              drv;
  logic               res_valid_o, res_ready_i;
  logic               out_valid_o, target_present_o, platform_seen_o, out_last_o;
  logic [7:0]         out_class_o;
  logic [15:0]        out_left_o, out_top_o, out_right_o, out_bottom_o, out_score_o;
  logic [31:0]        out_frame_o;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata, prdata;

  detection_presence_tracker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .box_valid_i      (drv.box_valid),
    .class_code_i     (drv.bx.cls),
    .left_x_i         (drv.bx.l),
    .top_y_i          (drv.bx.t),
    .right_x_i        (drv.bx.r),
    .bottom_y_i       (drv.bx.b),
    .confidence_i     (drv.bx.score),
    .frame_number_i   (drv.frame),
    .frame_last_i     (drv.last),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .out_valid_o      (out_valid_o),
    .out_class_o      (out_class_o),
    .out_left_o       (out_left_o),
    .out_top_o        (out_top_o),
    .out_right_o      (out_right_o),
    .out_bottom_o     (out_bottom_o),
    .out_score_o      (out_score_o),
    .out_frame_o      (out_frame_o),
    .target_present_o (target_present_o),
    .platform_seen_o  (platform_seen_o),
    .out_last_o       (out_last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  presence_scoreboard tracker_sb;

  // Stimulus controls shared between the sender, the receiver and the main flow.
  bit          quiet;      // no random idling on either side while set
  bit          hold_req;   // asks the receiver for one long hold-off
  int unsigned items_sent;
  logic [31:0] frame_no;
  item_t       frame_items[$];

  // The tracked object: a box that wanders a little from frame to frame.
  logic [7:0]  trk_cls;
  int          trk_l, trk_t, trk_w, trk_h;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Accepted result beats are sampled at the rising edge and checked in order.
  always @(posedge clk_i) begin
    beat_t r;
    if (rst_ni && res_valid_o && res_ready_i) begin
      r.vld = out_valid_o;
      r.bx.cls = out_class_o;
      r.bx.l = out_left_o;
      r.bx.t = out_top_o;
      r.bx.r = out_right_o;
      r.bx.b = out_bottom_o;
      r.bx.score = out_score_o;
      r.frame = out_frame_o;
      r.present = target_present_o;
      r.plat = platform_seen_o;
      r.last = out_last_o;
      tracker_sb.check_result(r);
    end
  end

  // Receiver: ready changes only at the falling edge. A hold-off request keeps it
  // low for a long stretch so that the tracker backs up and stalls its input.
  initial begin
    res_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 0;
      end else begin
        res_ready_i = quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  // Sends one input beat; valid stays high with a steady payload until accepted.
  task send_item(item_t it);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    drv = it;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    tracker_sb.note_item(it);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task write_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'(idx * 4);
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    tracker_sb.set_reg(idx, v);
  endtask

  task set_all(logic [15:0] conf, logic [15:0] snap, logic [15:0] alp,
               logic [7:0] ent, logic [7:0] ext, logic [7:0] meta, logic [7:0] plat);
    write_reg(REG_IOU_CONFIRM, {16'hdead, conf});
    write_reg(REG_IOU_SNAP, 32'(snap));
    write_reg(REG_BLEND_ALPHA, 32'(alp));
    write_reg(REG_ENTER, 32'(ent));
    write_reg(REG_EXIT, 32'(ext));
    write_reg(REG_META_BASE, 32'(meta));
    write_reg(REG_PLATFORM, 32'(plat));
  endtask

  // Waits until every expected beat has come back, then lets the sequencer settle.
  task drain();
    while (tracker_sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function item_t make_box(logic [7:0] c, logic [15:0] l, logic [15:0] t,
                           logic [15:0] r, logic [15:0] b, logic [15:0] s);
    item_t it;
    it.box_valid = 1'b1;
    it.bx = '{cls: c, l: l, t: t, r: r, b: b, score: s};
    it.frame = $urandom;
    it.last = 1'b0;
    return it;
  endfunction

  function item_t rand_box(logic [7:0] c);
    return make_box(c, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
  endfunction

  function item_t track_box();
    int l, t;
    l = trk_l + $urandom_range(0, 24) - 12;
    t = trk_t + $urandom_range(0, 24) - 12;
    return make_box(trk_cls, 16'(l), 16'(t), 16'(l + trk_w + $urandom_range(0, 16)),
                    16'(t + trk_h + $urandom_range(0, 16)), 16'($urandom));
  endfunction

  function void new_track(logic [7:0] meta);
    trk_cls = (meta == 0) ? 8'd0 : 8'($urandom_range(0, meta - 1));
    trk_w = $urandom_range(300, 6000);
    trk_h = $urandom_range(300, 6000);
    trk_l = $urandom_range(20, 65535 - trk_w - 40);
    trk_t = $urandom_range(20, 65535 - trk_h - 40);
  endfunction

  // Sends the collected frame; an empty frame becomes a single empty beat. Now and
  // then an ignored empty beat with junk fields is slipped in at the frame's start.
  task send_frame();
    item_t it;
    if (frame_items.size() == 0) begin
      it = rand_box(8'($urandom));
      it.box_valid = 1'b0;
      frame_items.push_back(it);
    end
    if ($urandom_range(99) < 10) begin
      it = rand_box(8'($urandom));
      it.box_valid = 1'b0;
      frame_items.push_front(it);
    end
    foreach (frame_items[i]) begin
      it = frame_items[i];
      it.frame = frame_no;
      it.last = (i == frame_items.size() - 1);
      send_item(it);
    end
    frame_items.delete();
    frame_no++;
  endtask

  // One random frame. Most frames follow the track so that the tracker confirms,
  // smooths and coasts; the rest are empty, marker-only, noise or oversized.
  task random_frame(logic [7:0] meta, logic [7:0] plat);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      frame_items.push_back(track_box());
      repeat ($urandom_range(0, 2)) frame_items.push_back(rand_box(8'($urandom)));
      if ($urandom_range(99) < 30) frame_items.push_back(rand_box(plat));
    end else if (pick < 75) begin
      if ($urandom_range(1)) begin
        frame_items.push_back(rand_box(plat));
        if (meta != 255) frame_items.push_back(rand_box(8'($urandom_range(meta, 255))));
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 3)) frame_items.push_back(rand_box(8'($urandom)));
    end else if (pick < 96) begin
      repeat ($urandom_range(3, 6)) frame_items.push_back(track_box());
    end else begin
      repeat ($urandom_range(16, 18)) frame_items.push_back(track_box());
    end
    if ($urandom_range(99) < 4) new_track(meta);
    send_frame();
  endtask

  task random_phase(int unsigned n_items, logic [7:0] meta, logic [7:0] plat);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    new_track(meta);
    while (items_sent < stop_at) random_frame(meta, plat);
  endtask

  initial begin
    item_t it;
    tracker_sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    drv = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet = 0;
    hold_req = 0;
    items_sent = 0;
    frame_no = $urandom;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames under near-default settings with a short entry run.
    set_all(RST_IOU_CONFIRM, RST_IOU_SNAP, RST_BLEND_ALPHA, 8'd2, RST_EXIT,
            RST_META_BASE, RST_PLATFORM);
    frame_no = 32'h0;
    send_frame();                               // a frame with no boxes at all
    frame_no = 32'hffff_ffff;
    it = make_box(8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    frame_items.push_back(it);
    it.box_valid = 1'b0;
    frame_items.push_back(it);                  // empty beat inside a frame
    frame_items.push_back(make_box(8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                   16'hffff));
    send_frame();
    // Same class, disjoint boxes in two frames: the overlap is zero, no entry.
    frame_items.push_back(make_box(8'd5, 16'd100, 16'd100, 16'd900, 16'd900, 16'd7));
    send_frame();
    frame_items.push_back(make_box(8'd5, 16'd5000, 16'd5000, 16'd5900, 16'd5900, 16'd9));
    send_frame();
    // An overfull frame: the boxes past the store depth are dropped.
    new_track(RST_META_BASE);
    repeat (NBOX + 1) frame_items.push_back(track_box());
    send_frame();
    drain();

    // Default-like settings with a long receiver hold-off while frames keep coming.
    set_all(RST_IOU_CONFIRM, RST_IOU_SNAP, RST_BLEND_ALPHA, 8'd2, RST_EXIT,
            RST_META_BASE, RST_PLATFORM);
    hold_req = 1;
    random_phase(50, RST_META_BASE, RST_PLATFORM);
    drain();

    // Low extremes: every overlap counts, enter and leave at once, one marker class.
    set_all(16'd0, 16'd0, 16'd0, 8'd1, 8'd1, 8'd255, 8'd255);
    quiet = 1;                                  // a long stretch with no idling
    random_phase(40, 8'd255, 8'd255);
    quiet = 0;
    drain();

    // High extremes: near-exact overlap only, entry never completes, no target classes.
    set_all(16'hffff, 16'hffff, 16'hffff, 8'd255, 8'd255, 8'd0, 8'd0);
    random_phase(30, 8'd0, 8'd0);
    drain();

    // Middle settings with a slow exit so that coasting frames are published.
    set_all(16'd20000, 16'd20000, 16'($urandom), 8'd3, 8'd4, 8'd200, 8'd201);
    random_phase(40, 8'd200, 8'd201);
    drain();

    if (tracker_sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(8 * 3000000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
